@@ rtl/core/aarm_pkg.sv @@
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix package
// Shared types, fixed-point constants and helper functions for the unit.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int unsigned QW         = 36;
  localparam int unsigned ATAN_STEPS = 24;
  localparam int unsigned SQ_STEPS   = 32;
  localparam int unsigned DIV_STEPS  = 31;

  localparam logic signed [QW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [QW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [QW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [QW-1:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [QW-1:0] Q_ONE       = 36'sd1073741824;
  localparam logic signed [15:0]   OUT_ONE     = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_axis;
  } out_item_t;

  typedef struct packed {
    logic               zero;
    logic               flip;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [63:0]        rem;
    logic [63:0]        root;
    logic [31:0]        len;
    logic [61:0]        nx;
    logic [61:0]        ny;
    logic [61:0]        nz;
    logic [30:0]        qx;
    logic [30:0]        qy;
    logic [30:0]        qz;
    logic signed [QW-1:0] c;
    logic signed [QW-1:0] s;
    logic signed [QW-1:0] t;
    logic signed [QW-1:0] pxx;
    logic signed [QW-1:0] pyy;
    logic signed [QW-1:0] pzz;
    logic signed [QW-1:0] pxy;
    logic signed [QW-1:0] pxz;
    logic signed [QW-1:0] pyz;
    logic signed [QW-1:0] sx;
    logic signed [QW-1:0] sy;
    logic signed [QW-1:0] sz;
  } stage_t;

  // Arctangent of 2^-i in Q30, truncated.
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Q30 product with round half up.
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b + (72'sd1 <<< 29);
    return p[QW+29:30];
  endfunction

  // Q30 to Q1.14 with rounding and saturation to plus or minus one.
  function automatic logic signed [15:0] to_out(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    r = (v + 36'sd32768) >>> 16;
    if (r > 36'sd16384) begin
      r = 36'sd16384;
    end else if (r < -36'sd16384) begin
      r = -36'sd16384;
    end
    return r[15:0];
  endfunction

endpackage

@@ rtl/core/aarm_in_if.sv @@
// ----------------------------------------------------------------------------
// Axis-angle input channel
// Valid/ready channel carrying one angle and axis word.
// ----------------------------------------------------------------------------
interface aarm_in_if;
  logic                valid;
  logic                ready;
  aarm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/aarm_out_if.sv @@
// ----------------------------------------------------------------------------
// Rotation matrix output channel
// Valid/ready channel carrying one 3x3 rotation block word.
// ----------------------------------------------------------------------------
interface aarm_out_if;
  logic                valid;
  logic                ready;
  aarm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/axis_angle_rotation_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix unit
// Rodrigues rotation block from an angle and an unnormalised axis, pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  in_i     in   angle (Q3.12), axis_x, axis_y, axis_z
//  out_o    out  m00..m22 (Q1.14), zero_axis
//
// One word is accepted every cycle unless the output register is stalled.
// The latency is set by the 32-step square-root chain and the 31-step
// restoring dividers that normalise the axis, plus the multiplier stages.
// Reset clears only the valid bits. A stall on the output freezes the whole
// pipeline, so nothing is lost or repeated.
module axis_angle_rotation_matrix_unit #(
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aarm_in_if.sink    in_i,
  aarm_out_if.source out_o
);
  import aarm_pkg::*;

  localparam int unsigned K_NUM  = SQ_STEPS;
  localparam int unsigned K_DIV0 = SQ_STEPS + 1;
  localparam int unsigned K_MUL1 = K_DIV0 + DIV_STEPS;
  localparam int unsigned K_MUL2 = K_MUL1 + 1;
  localparam int unsigned NST    = K_MUL2 + 1;

  stage_t          pipe_q [NST+1];
  stage_t          nxt    [NST];
  stage_t          front;
  logic [NST:0]    valid_q;
  out_item_t       out_d, out_q;
  logic            out_valid_q;
  logic            advance;

  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Angle reduction, axis energy and CORDIC seed.
  always_comb begin
    logic signed [QW-1:0] ang;
    logic signed [31:0]   sqx, sqy, sqz;
    logic [32:0]          n2;
    front = '0;
    ang = {{2{in_i.data.angle[15]}}, in_i.data.angle, 18'd0};
    if (ang > PI_Q30) begin
      ang = ang - TWO_PI_Q30;
    end else if (ang < -PI_Q30) begin
      ang = ang + TWO_PI_Q30;
    end
    if (ang > HALF_PI_Q30) begin
      ang = ang - PI_Q30;
      front.flip = 1'b1;
    end else if (ang < -HALF_PI_Q30) begin
      ang = ang + PI_Q30;
      front.flip = 1'b1;
    end
    sqx = in_i.data.axis_x * in_i.data.axis_x;
    sqy = in_i.data.axis_y * in_i.data.axis_y;
    sqz = in_i.data.axis_z * in_i.data.axis_z;
    n2  = 33'(unsigned'(sqx)) + 33'(unsigned'(sqy)) + 33'(unsigned'(sqz));
    front.zero = (in_i.data.axis_x == 16'sd0) && (in_i.data.axis_y == 16'sd0) &&
                 (in_i.data.axis_z == 16'sd0);
    front.x    = GAIN_Q30;
    front.y    = '0;
    front.z    = ang;
    front.ax   = in_i.data.axis_x;
    front.ay   = in_i.data.axis_y;
    front.az   = in_i.data.axis_z;
    front.rem  = {n2[31:0], 32'd0};
    front.root = '0;
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    always_comb begin
      logic [63:0]          bitv, trial;
      logic signed [QW-1:0] dx, dy, ux, uy, uz;
      logic [61:0]          dv;
      logic [15:0]          mx, my, mz;
      nxt[k] = pipe_q[k];
      bitv = '0; trial = '0; dx = '0; dy = '0; ux = '0; uy = '0; uz = '0;
      dv = '0; mx = '0; my = '0; mz = '0;
      if (k < SQ_STEPS) begin
        // One bit of the integer square root per stage.
        bitv  = 64'd1 << (62 - 2 * k);
        trial = pipe_q[k].root + bitv;
        if (pipe_q[k].rem >= trial) begin
          nxt[k].rem  = pipe_q[k].rem - trial;
          nxt[k].root = (pipe_q[k].root >> 1) + bitv;
        end else begin
          nxt[k].root = pipe_q[k].root >> 1;
        end
        if (k < TRIG_ITERATIONS && k < ATAN_STEPS) begin
          dx = pipe_q[k].y >>> k;
          dy = pipe_q[k].x >>> k;
          if (pipe_q[k].z >= 0) begin
            nxt[k].x = pipe_q[k].x - dx;
            nxt[k].y = pipe_q[k].y + dy;
            nxt[k].z = pipe_q[k].z - QW'(atan_q30(k));
          end else begin
            nxt[k].x = pipe_q[k].x + dx;
            nxt[k].y = pipe_q[k].y - dy;
            nxt[k].z = pipe_q[k].z + QW'(atan_q30(k));
          end
        end
      end else if (k == K_NUM) begin
        mx = pipe_q[k].ax[15] ? 16'(-pipe_q[k].ax) : pipe_q[k].ax;
        my = pipe_q[k].ay[15] ? 16'(-pipe_q[k].ay) : pipe_q[k].ay;
        mz = pipe_q[k].az[15] ? 16'(-pipe_q[k].az) : pipe_q[k].az;
        nxt[k].len = pipe_q[k].root[31:0];
        nxt[k].nx  = {mx, 46'd0} + 62'(pipe_q[k].root[31:1]);
        nxt[k].ny  = {my, 46'd0} + 62'(pipe_q[k].root[31:1]);
        nxt[k].nz  = {mz, 46'd0} + 62'(pipe_q[k].root[31:1]);
        nxt[k].qx  = '0;
        nxt[k].qy  = '0;
        nxt[k].qz  = '0;
        nxt[k].c   = pipe_q[k].flip ? -pipe_q[k].x : pipe_q[k].x;
        nxt[k].s   = pipe_q[k].flip ? -pipe_q[k].y : pipe_q[k].y;
        nxt[k].t   = Q_ONE - (pipe_q[k].flip ? -pipe_q[k].x : pipe_q[k].x);
      end else if (k < K_MUL1) begin
        // Restoring division, one quotient bit per stage, most significant first.
        dv = 62'(pipe_q[k].len) << (DIV_STEPS - 1 - (k - K_DIV0));
        if (pipe_q[k].nx >= dv) begin
          nxt[k].nx = pipe_q[k].nx - dv;
          nxt[k].qx[DIV_STEPS - 1 - (k - K_DIV0)] = 1'b1;
        end
        if (pipe_q[k].ny >= dv) begin
          nxt[k].ny = pipe_q[k].ny - dv;
          nxt[k].qy[DIV_STEPS - 1 - (k - K_DIV0)] = 1'b1;
        end
        if (pipe_q[k].nz >= dv) begin
          nxt[k].nz = pipe_q[k].nz - dv;
          nxt[k].qz[DIV_STEPS - 1 - (k - K_DIV0)] = 1'b1;
        end
      end else if (k == K_MUL1) begin
        ux = pipe_q[k].ax[15] ? -QW'(pipe_q[k].qx) : QW'(pipe_q[k].qx);
        uy = pipe_q[k].ay[15] ? -QW'(pipe_q[k].qy) : QW'(pipe_q[k].qy);
        uz = pipe_q[k].az[15] ? -QW'(pipe_q[k].qz) : QW'(pipe_q[k].qz);
        nxt[k].pxx = mulq(ux, ux);
        nxt[k].pyy = mulq(uy, uy);
        nxt[k].pzz = mulq(uz, uz);
        nxt[k].pxy = mulq(ux, uy);
        nxt[k].pxz = mulq(ux, uz);
        nxt[k].pyz = mulq(uy, uz);
        nxt[k].sx  = mulq(ux, pipe_q[k].s);
        nxt[k].sy  = mulq(uy, pipe_q[k].s);
        nxt[k].sz  = mulq(uz, pipe_q[k].s);
      end else begin
        nxt[k].pxx = mulq(pipe_q[k].pxx, pipe_q[k].t);
        nxt[k].pyy = mulq(pipe_q[k].pyy, pipe_q[k].t);
        nxt[k].pzz = mulq(pipe_q[k].pzz, pipe_q[k].t);
        nxt[k].pxy = mulq(pipe_q[k].pxy, pipe_q[k].t);
        nxt[k].pxz = mulq(pipe_q[k].pxz, pipe_q[k].t);
        nxt[k].pyz = mulq(pipe_q[k].pyz, pipe_q[k].t);
      end
    end
  end

  always_comb begin
    stage_t l;
    l = pipe_q[NST];
    if (l.zero) begin
      out_d = '0;
      out_d.m00 = OUT_ONE;
      out_d.m11 = OUT_ONE;
      out_d.m22 = OUT_ONE;
      out_d.zero_axis = 1'b1;
    end else begin
      out_d.m00 = to_out(l.c + l.pxx);
      out_d.m01 = to_out(l.pxy - l.sz);
      out_d.m02 = to_out(l.pxz + l.sy);
      out_d.m10 = to_out(l.pxy + l.sz);
      out_d.m11 = to_out(l.c + l.pyy);
      out_d.m12 = to_out(l.pyz - l.sx);
      out_d.m20 = to_out(l.pxz - l.sy);
      out_d.m21 = to_out(l.pyz + l.sx);
      out_d.m22 = to_out(l.c + l.pzz);
      out_d.zero_axis = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid_q     <= {valid_q[NST-1:0], in_i.valid};
      out_valid_q <= valid_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pipe_q[0] <= front;
      for (int unsigned k = 0; k < NST; k++) begin
        pipe_q[k+1] <= nxt[k];
      end
      out_q <= out_d;
    end
  end

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready))
    else $error("input ready does not follow the output stage");

  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NST] && in_i.ready |=> out_o.valid)
    else $error("finished word did not reach the output register");

  a_zero_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.zero_axis |->
      out_o.data.m00 == OUT_ONE && out_o.data.m11 == OUT_ONE &&
      out_o.data.m22 == OUT_ONE && out_o.data.m01 == 16'sd0)
    else $error("zero axis did not give the identity block");

endmodule
